// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file rfk_check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define RFK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rfk check failed");

// Overlapping implication checked outside reset.
`define RFK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfk check failed");

`endif

// ===== src/rfk_pkg.sv =====
// ----------------------------------------------------------------------------
// rfk_pkg
// Types and constants shared by the rank fusion top-k block.
// ----------------------------------------------------------------------------
package rfk_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int RESULT_CAP  = 64;
    localparam int EMIT_CAP    = (RESULT_CAP < MAX_ENTRIES) ? RESULT_CAP : MAX_ENTRIES;
    localparam int RANK_W      = 7;
    localparam int SUM_W       = 24;
    localparam int DIV_W       = 40;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RANK_W-1:0] RANK_MAX   = 7'd127;
    localparam logic [15:0]       GAIN_UNITY = 16'd4096;
    localparam logic [15:0]       SCORE_MAX  = 16'd32768;
    localparam logic [SUM_W-1:0]  SUM_MAX    = 24'hFFFFFF;

    localparam logic [1:0] ACT_SPARSE = 2'd0;
    localparam logic [1:0] ACT_DENSE  = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    localparam logic [1:0] LANE_SPARSE = 2'b01;
    localparam logic [1:0] LANE_DENSE  = 2'b10;
    localparam logic [1:0] LANE_BOTH   = 2'b11;

    localparam logic [1:0] CODE_BOTH   = 2'd0;
    localparam logic [1:0] CODE_SPARSE = 2'd1;
    localparam logic [1:0] CODE_DENSE  = 2'd2;

    localparam logic [1:0] AUTH_NORMATIVE = 2'd0;
    localparam logic [1:0] AUTH_REFERENCE = 2'd1;
    localparam logic [1:0] AUTH_ADVISORY  = 2'd2;
    localparam logic [1:0] AUTH_OTHER     = 2'd3;

    localparam logic [2:0] REG_FUSION_OFFSET  = 3'd0;
    localparam logic [2:0] REG_RESULT_LIMIT   = 3'd1;
    localparam logic [2:0] REG_SCORE_CUTOFF   = 3'd2;
    localparam logic [2:0] REG_NORMATIVE_GAIN = 3'd3;
    localparam logic [2:0] REG_REFERENCE_GAIN = 3'd4;
    localparam logic [2:0] REG_ADVISORY_GAIN  = 3'd5;
    localparam logic [2:0] REG_STALE_GAIN     = 3'd6;
    localparam logic [2:0] REG_STALE_READS    = 3'd7;

    typedef enum logic [1:0] {
        OP_SPARSE = 2'd0,
        OP_DENSE  = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    typedef struct packed {
        logic [7:0]  fusion_offset;
        logic [6:0]  result_limit;
        logic [15:0] score_cutoff;
        logic [15:0] normative_gain;
        logic [15:0] reference_gain;
        logic [15:0] advisory_gain;
        logic [15:0] stale_gain;
        logic        stale_reads;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] key;
        logic [15:0] score;
        logic [1:0]  auth;
        logic        degraded;
    } item_t;

    typedef struct packed {
        logic [31:0]      key;
        logic [SUM_W-1:0] sum;
        logic [15:0]      best;
        logic [1:0]       auth;
        logic [1:0]       lanes;
    } entry_t;

    typedef struct packed {
        logic        strobe;
        logic [31:0] key;
        logic [15:0] fused;
        logic [15:0] kept;
        logic [1:0]  auth;
        logic [1:0]  lane;
        logic        stale;
        logic        degraded;
        logic        empty;
        logic        overflow;
        logic        last;
    } result_t;

endpackage

// ===== src/rfk_ram.sv =====
// ----------------------------------------------------------------------------
// rfk_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rfk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/rfk_div.sv =====
// ----------------------------------------------------------------------------
// rfk_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfk_div
    import rfk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [SUM_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    logic [SUM_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [SUM_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [SUM_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvs_reg  <= divisor;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so it fits in SUM_W bits
            rem_reg <= fits ? SUM_W'(trial - {1'b0, dvs_reg}) : trial[SUM_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== src/rfk_front.sv =====
// ----------------------------------------------------------------------------
// rfk_front
// Accepts command items, decodes the action and queues them for the back end.
// ----------------------------------------------------------------------------
module rfk_front
    import rfk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] chunk_key,
    input  logic [15:0] recall_score,
    input  logic [1:0]  authority,
    input  logic        degraded_in,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;
    logic               accept;
    logic               push;
    logic               pop;
    item_t              dec_item;

    assign busy   = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign accept = start && !busy;

    // unused action code is accepted and dropped here
    always_comb
    begin
        dec_item          = '0;
        dec_item.key      = chunk_key;
        dec_item.score    = recall_score;
        dec_item.auth     = authority;
        dec_item.degraded = degraded_in;
        push              = accept;
        unique case (action)
            ACT_SPARSE: dec_item.op = OP_SPARSE;
            ACT_DENSE:  dec_item.op = OP_DENSE;
            ACT_FINISH: dec_item.op = OP_FINISH;
            default:    push = 1'b0;
        endcase
    end

    assign pop = q_pop && (fill_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= dec_item;
        end
    end

    assign q_valid = (fill_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

endmodule

// ===== src/rfk_back.sv =====
// ----------------------------------------------------------------------------
// rfk_back
// Sequencer: key table search and update per hit, normalize and ranked
// emission on finish.
// ----------------------------------------------------------------------------
module rfk_back
    import rfk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output result_t res
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_H_RD, ST_H_CMP, ST_H_WAIT,
        ST_P_RD, ST_P_CMP,
        ST_N_RD, ST_N_LAT, ST_N_WAIT, ST_N_M1, ST_N_M2, ST_N_WR,
        ST_C_RD, ST_C_CMP, ST_C_END,
        ST_S_RD, ST_S_CMP, ST_S_END
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [RANK_W-1:0] sparse_rank_reg;
    logic [RANK_W-1:0] dense_rank_reg;
    logic              ovf_reg;
    item_t             item_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  fidx_reg;
    logic [SUM_W-1:0]  peak_reg;
    logic [1:0]        auth_reg;
    logic [31:0]       prod1_reg;
    logic [35:0]       prod2_reg;
    logic [CNT_W-1:0]  kept_reg;
    logic [CNT_W-1:0]  emitted_reg;
    logic              prev_valid_reg;
    logic [15:0]       prev_f_reg;
    logic [31:0]       prev_k_reg;
    logic              best_valid_reg;
    logic [15:0]       best_f_reg;
    entry_t            best_e_reg;
    result_t           res_reg;

    // RAM and divider controls
    logic             ent_we;
    logic [IDX_W-1:0] ent_waddr;
    entry_t           ent_wdata;
    logic             rd_en;
    entry_t           ent_rdata;
    logic             fus_we;
    logic [15:0]      fus_wdata;
    logic [15:0]      fus_rdata;
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [SUM_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_q;
    logic             div_done;

    logic [RANK_W-1:0] cur_rank;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  share;
    logic [15:0]       gain;
    logic [15:0]       quot16;
    logic [19:0]       v1;
    logic [20:0]       v_pre;
    logic [15:0]       v_clamp;
    logic [CNT_W-1:0]  limit;
    logic              key_hit;
    logic              elig;
    logic              better;
    logic              at_end;

    assign at_end   = (idx_reg == count_reg);
    assign cur_rank = (q_item.op == OP_SPARSE) ? sparse_rank_reg : dense_rank_reg;
    assign share    = div_q[SUM_W-1:0];
    assign sum_add  = {1'b0, ent_rdata.sum} + {1'b0, share};
    assign key_hit  = (ent_rdata.key == item_reg.key);

    always_comb
    begin
        unique case (auth_reg)
            AUTH_NORMATIVE: gain = cfg.normative_gain;
            AUTH_REFERENCE: gain = cfg.reference_gain;
            AUTH_ADVISORY:  gain = cfg.advisory_gain;
            AUTH_OTHER:     gain = GAIN_UNITY;
        endcase
    end

    // sum <= peak, so the quotient never exceeds 2^15
    assign quot16  = (peak_reg == '0) ? 16'd0 : div_q[15:0];
    assign v1      = prod1_reg[31:12];
    assign v_pre   = cfg.stale_reads ? prod2_reg[35:15] : {1'b0, v1};
    assign v_clamp = (v_pre > {5'd0, SCORE_MAX}) ? SCORE_MAX : v_pre[15:0];

    assign limit = ({1'b0, cfg.result_limit} > 8'(EMIT_CAP)) ? CNT_W'(EMIT_CAP)
                                                            : CNT_W'(cfg.result_limit);

    // selection rounds walk the total order: score down, then key up
    assign elig   = (fus_rdata >= cfg.score_cutoff) &&
                    (!prev_valid_reg || (fus_rdata < prev_f_reg) ||
                     ((fus_rdata == prev_f_reg) && (ent_rdata.key > prev_k_reg)));
    assign better = !best_valid_reg || (fus_rdata > best_f_reg) ||
                    ((fus_rdata == best_f_reg) && (ent_rdata.key < best_e_reg.key));

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        ent_we       = 1'b0;
        ent_waddr    = fidx_reg;
        ent_wdata    = ent_rdata;
        fus_we       = 1'b0;
        fus_wdata    = v_clamp;
        rd_en        = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(1) << 23;
        div_divisor  = SUM_W'(cfg.fusion_offset) + SUM_W'(cur_rank) + SUM_W'(1);
        unique case (state_reg)
            ST_IDLE:
            begin
                div_start = q_valid && (q_item.op != OP_FINISH);
            end
            ST_H_RD, ST_P_RD, ST_N_RD, ST_C_RD, ST_S_RD:
            begin
                rd_en = !at_end;
            end
            ST_H_WAIT:
            begin
                if (div_done)
                begin
                    if (found_reg)
                    begin
                        ent_we          = 1'b1;
                        ent_wdata.sum   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                        ent_wdata.lanes = ent_rdata.lanes |
                                          ((item_reg.op == OP_SPARSE) ? LANE_SPARSE
                                                                      : LANE_DENSE);
                        if (item_reg.score > ent_rdata.best)
                        begin
                            ent_wdata.best = item_reg.score;
                            ent_wdata.auth = item_reg.auth;
                        end
                    end
                    else if (count_reg != CNT_W'(MAX_ENTRIES))
                    begin
                        ent_we          = 1'b1;
                        ent_waddr       = count_reg[IDX_W-1:0];
                        ent_wdata.key   = item_reg.key;
                        ent_wdata.sum   = share;
                        ent_wdata.best  = item_reg.score;
                        ent_wdata.auth  = item_reg.auth;
                        ent_wdata.lanes = (item_reg.op == OP_SPARSE) ? LANE_SPARSE
                                                                     : LANE_DENSE;
                    end
                end
            end
            ST_N_LAT:
            begin
                div_start    = (peak_reg != '0);
                div_dividend = DIV_W'({ent_rdata.sum, 15'd0});
                div_divisor  = peak_reg;
            end
            ST_N_WR:
            begin
                fus_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    rfk_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (rd_en),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ent_rdata)
    );

    rfk_ram #(
        .WIDTH (16),
        .DEPTH (MAX_ENTRIES)
    ) u_fused_ram (
        .clk   (clk),
        .we    (fus_we),
        .waddr (idx_reg[IDX_W-1:0]),
        .wdata (fus_wdata),
        .re    (rd_en),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (fus_rdata)
    );

    rfk_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            count_reg       <= '0;
            sparse_rank_reg <= '0;
            dense_rank_reg  <= '0;
            ovf_reg         <= 1'b0;
            item_reg        <= '0;
            found_reg       <= 1'b0;
            fidx_reg        <= '0;
            peak_reg        <= '0;
            auth_reg        <= '0;
            prod1_reg       <= '0;
            prod2_reg       <= '0;
            kept_reg        <= '0;
            emitted_reg     <= '0;
            prev_valid_reg  <= 1'b0;
            prev_f_reg      <= '0;
            prev_k_reg      <= '0;
            best_valid_reg  <= 1'b0;
            best_f_reg      <= '0;
            best_e_reg      <= '0;
            res_reg         <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    res_reg.strobe <= 1'b0;
                    if (q_valid)
                    begin
                        item_reg <= q_item;
                        idx_reg  <= '0;
                        unique case (q_item.op)
                            OP_SPARSE:
                            begin
                                if (sparse_rank_reg < RANK_MAX)
                                begin
                                    sparse_rank_reg <= sparse_rank_reg + 1'b1;
                                end
                                found_reg <= 1'b0;
                                state_reg <= ST_H_RD;
                            end
                            OP_DENSE:
                            begin
                                if (dense_rank_reg < RANK_MAX)
                                begin
                                    dense_rank_reg <= dense_rank_reg + 1'b1;
                                end
                                found_reg <= 1'b0;
                                state_reg <= ST_H_RD;
                            end
                            OP_FINISH:
                            begin
                                peak_reg  <= '0;
                                state_reg <= ST_P_RD;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_H_RD:
                begin
                    state_reg <= at_end ? ST_H_WAIT : ST_H_CMP;
                end
                ST_H_CMP:
                begin
                    if (key_hit)
                    begin
                        found_reg <= 1'b1;
                        fidx_reg  <= idx_reg[IDX_W-1:0];
                        state_reg <= ST_H_WAIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_H_RD;
                    end
                end
                ST_H_WAIT:
                begin
                    if (div_done)
                    begin
                        if (!found_reg)
                        begin
                            if (count_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                ovf_reg <= 1'b1;
                            end
                            else
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_P_RD:
                begin
                    if (at_end)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_N_RD;
                    end
                    else
                    begin
                        state_reg <= ST_P_CMP;
                    end
                end
                ST_P_CMP:
                begin
                    if (ent_rdata.sum > peak_reg)
                    begin
                        peak_reg <= ent_rdata.sum;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_P_RD;
                end
                ST_N_RD:
                begin
                    if (at_end)
                    begin
                        idx_reg   <= '0;
                        kept_reg  <= '0;
                        state_reg <= ST_C_RD;
                    end
                    else
                    begin
                        state_reg <= ST_N_LAT;
                    end
                end
                ST_N_LAT:
                begin
                    auth_reg  <= ent_rdata.auth;
                    state_reg <= (peak_reg == '0) ? ST_N_M1 : ST_N_WAIT;
                end
                ST_N_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_N_M1;
                    end
                end
                ST_N_M1:
                begin
                    prod1_reg <= quot16 * gain;
                    state_reg <= ST_N_M2;
                end
                ST_N_M2:
                begin
                    prod2_reg <= v1 * cfg.stale_gain;
                    state_reg <= ST_N_WR;
                end
                ST_N_WR:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_N_RD;
                end
                ST_C_RD:
                begin
                    state_reg <= at_end ? ST_C_END : ST_C_CMP;
                end
                ST_C_CMP:
                begin
                    if (fus_rdata >= cfg.score_cutoff)
                    begin
                        kept_reg <= kept_reg + 1'b1;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_C_RD;
                end
                ST_C_END:
                begin
                    idx_reg        <= '0;
                    emitted_reg    <= '0;
                    prev_valid_reg <= 1'b0;
                    best_valid_reg <= 1'b0;
                    if ((kept_reg == '0) || (limit == '0))
                    begin
                        res_reg <= '{strobe: 1'b1, key: '0, fused: '0, kept: '0,
                                     auth: '0, lane: '0, stale: 1'b0,
                                     degraded: item_reg.degraded, empty: 1'b1,
                                     overflow: ovf_reg, last: 1'b1};
                        count_reg       <= '0;
                        sparse_rank_reg <= '0;
                        dense_rank_reg  <= '0;
                        ovf_reg         <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                    else
                    begin
                        if (kept_reg > limit)
                        begin
                            kept_reg <= limit;
                        end
                        state_reg <= ST_S_RD;
                    end
                end
                ST_S_RD:
                begin
                    res_reg.strobe <= 1'b0;
                    state_reg      <= at_end ? ST_S_END : ST_S_CMP;
                end
                ST_S_CMP:
                begin
                    if (elig && better)
                    begin
                        best_valid_reg <= 1'b1;
                        best_f_reg     <= fus_rdata;
                        best_e_reg     <= ent_rdata;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_S_RD;
                end
                ST_S_END:
                begin
                    res_reg.strobe   <= 1'b1;
                    res_reg.key      <= best_e_reg.key;
                    res_reg.fused    <= best_f_reg;
                    res_reg.kept     <= best_e_reg.best;
                    res_reg.auth     <= best_e_reg.auth;
                    res_reg.lane     <= (best_e_reg.lanes == LANE_BOTH)   ? CODE_BOTH :
                                        (best_e_reg.lanes == LANE_SPARSE) ? CODE_SPARSE
                                                                          : CODE_DENSE;
                    res_reg.stale    <= cfg.stale_reads;
                    res_reg.degraded <= item_reg.degraded;
                    res_reg.empty    <= 1'b0;
                    res_reg.overflow <= ovf_reg;
                    res_reg.last     <= (emitted_reg + 1'b1 == kept_reg);
                    prev_valid_reg   <= 1'b1;
                    prev_f_reg       <= best_f_reg;
                    prev_k_reg       <= best_e_reg.key;
                    best_valid_reg   <= 1'b0;
                    emitted_reg      <= emitted_reg + 1'b1;
                    idx_reg          <= '0;
                    if (emitted_reg + 1'b1 == kept_reg)
                    begin
                        count_reg       <= '0;
                        sparse_rank_reg <= '0;
                        dense_rank_reg  <= '0;
                        ovf_reg         <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_S_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

// ===== src/rank_fusion_top_k_core.sv =====
// ----------------------------------------------------------------------------
// rank_fusion_top_k_core
// Reciprocal rank fusion of two retrieval lanes with ranked top-k emission.
// ----------------------------------------------------------------------------
// Items are taken into a two-deep queue; busy is high only while it is full.
// Every item is taken from the queue in the idle state. For a hit the table in
// RAM is searched entry by entry, with a read and a compare state per entry,
// while the bit-serial divider forms the rank share. Finish then runs a peak
// scan, a per-entry normalize (divider plus two multiplies; the divider is
// skipped when every sum is zero), a counting pass, and one full selection
// scan of the table per emitted result. Results come out one per strobe cycle
// and cannot be held off; the receiver must take each as it appears. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module rank_fusion_top_k_core
    import rfk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] chunk_key,
    input  logic [15:0] recall_score,
    input  logic [1:0]  authority,
    input  logic        degraded_in,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        strobe,
    output logic [31:0] out_key,
    output logic [15:0] score_q15,
    output logic [15:0] kept_score,
    output logic [1:0]  out_authority,
    output logic [1:0]  lane_code,
    output logic        stale_applied,
    output logic        degraded,
    output logic        empty_set,
    output logic        overflow,
    output logic        last
);

    cfg_t    cfg_reg;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fusion_offset  <= 8'd60;
            cfg_reg.result_limit   <= 7'd10;
            cfg_reg.score_cutoff   <= 16'd0;
            cfg_reg.normative_gain <= GAIN_UNITY;
            cfg_reg.reference_gain <= GAIN_UNITY;
            cfg_reg.advisory_gain  <= GAIN_UNITY;
            cfg_reg.stale_gain     <= SCORE_MAX;
            cfg_reg.stale_reads    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FUSION_OFFSET:  cfg_reg.fusion_offset  <= cfg_data[7:0];
                REG_RESULT_LIMIT:   cfg_reg.result_limit   <= cfg_data[6:0];
                REG_SCORE_CUTOFF:   cfg_reg.score_cutoff   <= cfg_data;
                REG_NORMATIVE_GAIN: cfg_reg.normative_gain <= cfg_data;
                REG_REFERENCE_GAIN: cfg_reg.reference_gain <= cfg_data;
                REG_ADVISORY_GAIN:  cfg_reg.advisory_gain  <= cfg_data;
                REG_STALE_GAIN:     cfg_reg.stale_gain     <= cfg_data;
                REG_STALE_READS:    cfg_reg.stale_reads    <= cfg_data[0];
            endcase
        end
    end

    rfk_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .chunk_key    (chunk_key),
        .recall_score (recall_score),
        .authority    (authority),
        .degraded_in  (degraded_in),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    rfk_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .res     (res)
    );

    assign strobe        = res.strobe;
    assign out_key       = res.key;
    assign score_q15     = res.fused;
    assign kept_score    = res.kept;
    assign out_authority = res.auth;
    assign lane_code     = res.lane;
    assign stale_applied = res.stale;
    assign degraded      = res.degraded;
    assign empty_set     = res.empty;
    assign overflow      = res.overflow;
    assign last          = res.last;

endmodule

// ===== src/rfk_check.sv =====
// ----------------------------------------------------------------------------
// rfk_check
// Port-level checks on the result stream of the rank fusion core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfk_check
    import rfk_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        strobe,
    input logic [31:0] out_key,
    input logic [15:0] score_q15,
    input logic [15:0] kept_score,
    input logic [1:0]  lane_code,
    input logic        stale_applied,
    input logic        empty_set,
    input logic        last
);

    // an empty run is a single result with cleared payload
    `RFK_ASSERT_IMP(a_empty_last, strobe && empty_set, last && (out_key == '0))
    `RFK_ASSERT_IMP(a_empty_zero, strobe && empty_set, (score_q15 == '0) && (kept_score == '0) && !stale_applied)
    `RFK_ASSERT_IMP(a_score_clamp, strobe, score_q15 <= SCORE_MAX)
    `RFK_ASSERT_IMP(a_lane_code, strobe, (lane_code == CODE_BOTH) || (lane_code == CODE_SPARSE) || (lane_code == CODE_DENSE))

endmodule

bind rank_fusion_top_k_core rfk_check u_check (.*);

// ===== tb/rank_fusion_top_k_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_fusion_top_k_core_tb
// Self-checking bench for the rank fusion top-k core. A built-in predictor
// keeps its own key table and registers, works out the ranked results of
// every finish item and compares each strobed result against them in order.
// ----------------------------------------------------------------------------
module rank_fusion_top_k_core_tb
    import rfk_pkg::*;
();

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] key;
        logic [15:0] fused;
        logic [15:0] kept;
        logic [1:0]  auth;
        logic [1:0]  lane;
        logic        stale;
        logic        degraded;
        logic        empty;
        logic        overflow;
        logic        last;
    } ranked_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [31:0] chunk_key;
    logic [15:0] recall_score;
    logic [1:0]  authority;
    logic        degraded_in;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        strobe;
    logic [31:0] out_key;
    logic [15:0] score_q15;
    logic [15:0] kept_score;
    logic [1:0]  out_authority;
    logic [1:0]  lane_code;
    logic        stale_applied;
    logic        degraded;
    logic        empty_set;
    logic        overflow;
    logic        last;

    rank_fusion_top_k_core uut (.*);

    // predictor state
    logic [31:0] tbl_key [MAX_ENTRIES];
    logic [31:0] tbl_sum [MAX_ENTRIES];
    logic [15:0] tbl_best [MAX_ENTRIES];
    logic [1:0]  tbl_auth [MAX_ENTRIES];
    logic [1:0]  tbl_lanes [MAX_ENTRIES];
    int          tbl_fill;
    int          rank_sparse;
    int          rank_dense;
    logic        dropped_key;
    cfg_t        regs;

    ranked_t     pending_results[$];
    int          errors;
    int          results_seen;
    int          items_sent;
    int          finishes_sent;
    int          burst_left;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("%0t: mismatch %s got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic clear_table();
        tbl_fill = 0;
        rank_sparse = 0;
        rank_dense = 0;
        dropped_key = 1'b0;
    endtask

    function automatic logic [31:0] gain_of(input logic [1:0] a);
        case (a)
            AUTH_NORMATIVE: return regs.normative_gain;
            AUTH_REFERENCE: return regs.reference_gain;
            AUTH_ADVISORY:  return regs.advisory_gain;
            default:        return GAIN_UNITY;
        endcase
    endfunction

    task automatic fuse_hit(input bit is_sparse, input logic [31:0] k,
                            input logic [15:0] sc, input logic [1:0] a);
        int r;
        int i;
        logic [31:0] share;
        logic [1:0] lane;
        r = is_sparse ? rank_sparse : rank_dense;
        share = (32'd1 << 23) / (regs.fusion_offset + r + 1);
        lane = is_sparse ? LANE_SPARSE : LANE_DENSE;
        if (r < RANK_MAX) begin
            if (is_sparse) rank_sparse++;
            else rank_dense++;
        end
        for (i = 0; i < tbl_fill; i++)
            if (tbl_key[i] == k) break;
        if (i == tbl_fill) begin
            if (tbl_fill >= MAX_ENTRIES) begin
                dropped_key = 1'b1;
            end
            else begin
                tbl_key[i] = k;
                tbl_sum[i] = share;
                tbl_best[i] = sc;
                tbl_auth[i] = a;
                tbl_lanes[i] = lane;
                tbl_fill++;
            end
        end
        else begin
            tbl_sum[i] = (tbl_sum[i] + share > SUM_MAX) ? SUM_MAX : tbl_sum[i] + share;
            tbl_lanes[i] |= lane;
            if (sc > tbl_best[i]) begin
                tbl_best[i] = sc;
                tbl_auth[i] = a;
            end
        end
    endtask

    task automatic rank_and_queue(input logic deg);
        logic [31:0] peak;
        logic [63:0] v;
        logic [31:0] score_of [MAX_ENTRIES];
        int order [MAX_ENTRIES];
        int kept;
        int lim;
        int j;
        int e;
        ranked_t r;
        peak = 0;
        kept = 0;
        for (int i = 0; i < tbl_fill; i++)
            if (tbl_sum[i] > peak) peak = tbl_sum[i];
        for (int i = 0; i < tbl_fill; i++) begin
            v = 0;
            if (peak > 0) v = ({32'd0, tbl_sum[i]} << 15) / peak;
            v = (v * gain_of(tbl_auth[i])) >> 12;
            if (regs.stale_reads) v = (v * regs.stale_gain) >> 15;
            if (v > 32768) v = 32768;
            score_of[i] = v[31:0];
        end
        for (int i = 0; i < tbl_fill; i++) begin
            if (score_of[i] < regs.score_cutoff) continue;
            j = kept;
            while (j > 0 && (score_of[i] > score_of[order[j-1]] ||
                   (score_of[i] == score_of[order[j-1]] &&
                    tbl_key[i] < tbl_key[order[j-1]]))) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
            kept++;
        end
        lim = (regs.result_limit > RESULT_CAP) ? RESULT_CAP : regs.result_limit;
        if (kept > lim) kept = lim;
        if (kept == 0) begin
            r = '{default: '0};
            r.degraded = deg;
            r.empty = 1'b1;
            r.overflow = dropped_key;
            r.last = 1'b1;
            pending_results.insert(pending_results.size(), r);
        end
        for (int n = 0; n < kept; n++) begin
            e = order[n];
            r.key = tbl_key[e];
            r.fused = score_of[e][15:0];
            r.kept = tbl_best[e];
            r.auth = tbl_auth[e];
            r.lane = (tbl_lanes[e] == LANE_BOTH) ? CODE_BOTH :
                     (tbl_lanes[e] == LANE_SPARSE) ? CODE_SPARSE : CODE_DENSE;
            r.stale = regs.stale_reads;
            r.degraded = deg;
            r.empty = 1'b0;
            r.overflow = dropped_key;
            r.last = (n + 1 == kept);
            pending_results.insert(pending_results.size(), r);
        end
        clear_table();
    endtask

    // result checker
    always @(posedge clk) begin
        ranked_t w;
        if (rst_n && strobe) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result key", out_key, 0);
            end
            else begin
                w = pending_results.pop_front();
                if (out_key !== w.key) report_mismatch("out_key", out_key, w.key);
                if (score_q15 !== w.fused) report_mismatch("score_q15", score_q15, w.fused);
                if (kept_score !== w.kept) report_mismatch("kept_score", kept_score, w.kept);
                if (out_authority !== w.auth)
                    report_mismatch("out_authority", out_authority, w.auth);
                if (lane_code !== w.lane) report_mismatch("lane_code", lane_code, w.lane);
                if (stale_applied !== w.stale)
                    report_mismatch("stale_applied", stale_applied, w.stale);
                if (degraded !== w.degraded) report_mismatch("degraded", degraded, w.degraded);
                if (empty_set !== w.empty) report_mismatch("empty_set", empty_set, w.empty);
                if (overflow !== w.overflow) report_mismatch("overflow", overflow, w.overflow);
                if (last !== w.last) report_mismatch("last", last, w.last);
            end
        end
    end

    // one item, with sender gaps between random-length bursts
    task automatic send_item(input logic [1:0] act, input logic [31:0] k,
                             input logic [15:0] sc, input logic [1:0] a,
                             input logic deg);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start = 1'b1;
        action <= act;
        chunk_key <= k;
        recall_score <= sc;
        authority <= a;
        degraded_in <= deg;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
        if (act == OP_SPARSE || act == OP_DENSE) fuse_hit(act == OP_SPARSE, k, sc, a);
        else if (act == OP_FINISH) begin
            rank_and_queue(deg);
            finishes_sent++;
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge clk);
        // finish clears its table together with its last strobe
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we = 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_FUSION_OFFSET:  regs.fusion_offset = val[7:0];
            REG_RESULT_LIMIT:   regs.result_limit = val[6:0];
            REG_SCORE_CUTOFF:   regs.score_cutoff = val;
            REG_NORMATIVE_GAIN: regs.normative_gain = val;
            REG_REFERENCE_GAIN: regs.reference_gain = val;
            REG_ADVISORY_GAIN:  regs.advisory_gain = val;
            REG_STALE_GAIN:     regs.stale_gain = val;
            REG_STALE_READS:    regs.stale_reads = val[0];
            default: ;
        endcase
    endtask

    task automatic send_hit(input logic [31:0] k);
        send_item(2'($urandom_range(0, 1)), k, 16'($urandom), 2'($urandom_range(0, 3)),
                  1'b0);
    endtask

    task automatic test_defaults();
        send_item(OP_FINISH, '0, '0, '0, 1'b1);              // empty table
        send_item(OP_SPARSE, 32'hFFFF_FFFF, 16'hFFFF, AUTH_NORMATIVE, 1'b0);
        send_item(OP_DENSE, 32'hFFFF_FFFF, 16'hFFFF, AUTH_REFERENCE, 1'b0); // tie
        send_item(OP_DENSE, 32'h0, 16'h0, AUTH_ADVISORY, 1'b0);
        send_item(OP_SPARSE, 32'h5555_AAAA, 16'h8000, AUTH_OTHER, 1'b0);
        send_item(OP_SPARSE, 32'hAAAA_5555, 16'h7FFF, AUTH_OTHER, 1'b0);
        send_item(ACT_UNUSED, 32'h1234, 16'h1, AUTH_NORMATIVE, 1'b1);   // ignored code
        send_item(OP_FINISH, '0, '0, '0, 1'b0);
        drain();
    endtask

    task automatic test_registers();
        write_reg(REG_FUSION_OFFSET, 16'd1);
        write_reg(REG_RESULT_LIMIT, 16'd127);
        write_reg(REG_NORMATIVE_GAIN, 16'hFFFF);
        write_reg(REG_REFERENCE_GAIN, 16'd1);
        write_reg(REG_ADVISORY_GAIN, 16'd8192);
        write_reg(REG_STALE_GAIN, 16'd1);
        write_reg(REG_STALE_READS, 16'd1);
        for (int i = 0; i < 6; i++) send_hit(i);
        send_item(OP_FINISH, '0, '0, '0, 1'b1);
        drain();
        write_reg(REG_STALE_GAIN, 16'd32768);
        write_reg(REG_SCORE_CUTOFF, 16'd32768);
        for (int i = 0; i < 4; i++) send_hit(i);
        send_item(OP_FINISH, '0, '0, '0, 1'b0);
        drain();
        write_reg(REG_RESULT_LIMIT, 16'd0);                  // forces empty result
        write_reg(REG_SCORE_CUTOFF, 16'd0);
        send_hit(7);
        send_item(OP_FINISH, '0, '0, '0, 1'b0);
        drain();
    endtask

    // overflow and sum saturation in one long query
    task automatic test_full_table();
        write_reg(REG_FUSION_OFFSET, 16'd1);
        write_reg(REG_RESULT_LIMIT, 16'd64);
        write_reg(REG_STALE_READS, 16'd0);
        for (int i = 0; i < 70; i++)
            send_item(OP_SPARSE, 32'h100 + i, 16'($urandom), 2'($urandom_range(0, 3)), 1'b0);
        for (int i = 0; i < 70; i++)
            send_item(OP_DENSE, 32'h100, 16'($urandom), 2'($urandom_range(0, 3)), 1'b0);
        send_item(OP_FINISH, '0, '0, '0, 1'b1);
        drain();
    endtask

    task automatic test_random_queries(input int n_items);
        int sent;
        int n_hits;
        int pool;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_FUSION_OFFSET, 16'($urandom_range(1, 200)));
                write_reg(REG_RESULT_LIMIT, 16'($urandom_range(1, 64)));
                write_reg(REG_SCORE_CUTOFF, $urandom_range(0, 3) == 0 ?
                          16'($urandom_range(0, 32768)) : 16'd0);
                write_reg(REG_NORMATIVE_GAIN, 16'($urandom_range(4096, 65535)));
                write_reg(REG_REFERENCE_GAIN, 16'($urandom_range(1, 65535)));
                write_reg(REG_ADVISORY_GAIN, 16'($urandom_range(1, 65535)));
                write_reg(REG_STALE_GAIN, 16'($urandom_range(1, 32768)));
                write_reg(REG_STALE_READS, 16'($urandom_range(0, 1)));
            end
            n_hits = $urandom_range(0, 14);
            pool = $urandom_range(1, 12);
            for (int i = 0; i < n_hits; i++) begin
                // small key pool makes repeats; full random key sometimes
                send_item($urandom_range(0, 9) == 0 ? ACT_UNUSED : 2'($urandom_range(0, 1)),
                          $urandom_range(0, 1) ? $urandom : $urandom_range(0, pool),
                          16'($urandom), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)));
                sent++;
            end
            send_item(OP_FINISH, $urandom, 16'($urandom), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)));
            sent++;
            if ($urandom_range(0, 4) == 0) drain();
            else while (pending_results.size() != 0) @(negedge clk);
        end
        drain();
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        action = OP_SPARSE;
        chunk_key = '0;
        recall_score = '0;
        authority = '0;
        degraded_in = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        results_seen = 0;
        items_sent = 0;
        finishes_sent = 0;
        burst_left = 0;
        regs = '{fusion_offset: 8'd60, result_limit: 7'd10, score_cutoff: 16'd0,
                 normative_gain: 16'd4096, reference_gain: 16'd4096,
                 advisory_gain: 16'd4096, stale_gain: 16'd32768, stale_reads: 1'b0};
        clear_table();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_defaults();
        test_registers();
        test_full_table();
        test_random_queries(90);
        $display("covered %0d items, %0d finishes, %0d ranked results checked",
                 items_sent, finishes_sent, results_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("rank_fusion_top_k_core test passed");
        else
            $display("rank_fusion_top_k_core test failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("rank_fusion_top_k_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/rfk_pkg.sv
src/rfk_ram.sv
src/rfk_div.sv
src/rfk_front.sv
src/rfk_back.sv
src/rank_fusion_top_k_core.sv
src/rfk_check.sv
tb/rank_fusion_top_k_core_tb.sv
